// File: sv/shsts_pkg.sv
// ----------------------------------------------------------------------------
// shsts_pkg
// shared types, codes and constants of the half-step task sequencer
// ----------------------------------------------------------------------------
package shsts_pkg;

	localparam int DUR_W     = 24;
	localparam int STEPS_W   = 16;
	localparam int TICKS_W   = 15;
	localparam int PROD_W    = 30;
	localparam int DIV_STEPS = DUR_W;
	localparam int CNT_W     = 5;

	// action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	// register indexes
	localparam logic CFG_MIN_TICKS = 1'b0;
	localparam logic CFG_MAX_TICKS = 1'b1;

	// direction codes
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd3;

	localparam logic [STEPS_W-1:0] DWELL_STEPS = 16'd100;
	// 255/80 reduces exactly to 51/16
	localparam logic [5:0]         TICK_SCALE  = 6'd51;
	localparam int                 TICK_SHIFT  = 4;

	localparam logic [TICKS_W-1:0] MIN_TICKS_RST = 15'd1;
	localparam logic [TICKS_W-1:0] MAX_TICKS_RST = 15'd32767;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCALE,
		ST_CLAMP
	} state_t;

	typedef struct packed {
		logic load_go;   // load with nonzero duration accepted
		logic stop_go;   // load with zero duration accepted
		logic step_go;   // step transaction accepted
		logic div_step;
		logic scale_en;
		logic clamp_en;
	} ctrl_cmd_t;

	typedef struct packed {
		logic dur_zero;
		logic out_blocked;
	} dp_status_t;

	function automatic logic [3:0] half_step_mask(input logic [2:0] ph);
		logic [3:0] m;
		case (ph)
			3'd0: m = 4'b0001;
			3'd1: m = 4'b0101;
			3'd2: m = 4'b0100;
			3'd3: m = 4'b0110;
			3'd4: m = 4'b0010;
			3'd5: m = 4'b1010;
			3'd6: m = 4'b1000;
			3'd7: m = 4'b1001;
			default: m = 4'b0001;
		endcase
		return m;
	endfunction

endpackage

// File: sv/stepper_half_step_task_sequencer_top.sv
// ----------------------------------------------------------------------------
// stepper_half_step_task_sequencer_top
// half-step coil sequencer for one stepper motor driven by move tasks
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries action, task_duration_us and
//   task_steps. a load transaction (action 0) sets up a move and gives no
//   result; a step transaction (action 1) gives one result on the output
//   channel (out_valid / out_stall): coil_levels, step_ticks, task_done and
//   holding, registered, in the cycle after acceptance.
//   step transactions and zero-duration loads let the next transaction follow
//   at once unless a stalled receiver holds a result. a load with nonzero
//   duration runs the step-length computation: the shift-subtract divider
//   (one quotient bit per cycle), then the 51/16 scaling multiply and then the
//   clamp; the next transaction is accepted only after the clamp.
//   in_stall is high during that computation and while a result is held by a
//   stalled receiver; a held result stays stable until taken.
//   configuration writes (cfg_we, cfg_index, cfg_data) are taken at any edge
//   and are meant for idle periods only.
//   reset: phase, step count, direction and step length clear, min clamp 1,
//   max clamp 32767, output channel empty.
// ----------------------------------------------------------------------------
module stepper_half_step_task_sequencer_top
	import shsts_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [TICKS_W-1:0]        cfg_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic [DUR_W-1:0]          task_duration_us,
	input  logic signed [STEPS_W-1:0] task_steps,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [3:0]                coil_levels,
	output logic [TICKS_W-1:0]        step_ticks,
	output logic                      task_done,
	output logic                      holding
);

	// command and status between controller and datapath
	ctrl_cmd_t  cmd;
	dp_status_t status;

	// controller: acceptance, divider iteration count, load sequencing
	shsts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// datapath: motor state, divider, scaling, clamp and result register
	shsts_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.task_duration_us (task_duration_us),
		.task_steps       (task_steps),
		.cmd              (cmd),
		.status           (status),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.coil_levels      (coil_levels),
		.step_ticks       (step_ticks),
		.task_done        (task_done),
		.holding          (holding)
	);

endmodule

// File: sv/shsts_ctrl.sv
// ----------------------------------------------------------------------------
// shsts_ctrl
// sequencing of input acceptance and of the task load computation
// ----------------------------------------------------------------------------
module shsts_ctrl
	import shsts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       action,
	input  dp_status_t status,
	output logic       in_stall,
	output ctrl_cmd_t  cmd
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] div_cnt_q;
	logic             accept;
	logic             last_div;

	assign last_div = (div_cnt_q == CNT_W'(DIV_STEPS - 1));
	assign in_stall = (state_q != ST_IDLE) | status.out_blocked;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_LOAD && !status.dur_zero) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (last_div) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load_go = accept & (action == ACT_LOAD) & ~status.dur_zero;
				cmd.stop_go = accept & (action == ACT_LOAD) & status.dur_zero;
				cmd.step_go = accept & (action == ACT_STEP);
			end
			ST_DIV:   cmd.div_step = 1'b1;
			ST_SCALE: cmd.scale_en = 1'b1;
			ST_CLAMP: cmd.clamp_en = 1'b1;
			default:  cmd = '0;
		endcase
	end

endmodule

// File: sv/shsts_datapath.sv
// ----------------------------------------------------------------------------
// shsts_datapath
// motor state, shift-subtract divider, tick scaling and clamp, result register
// ----------------------------------------------------------------------------
module shsts_datapath
	import shsts_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [TICKS_W-1:0]        cfg_data,
	input  logic [DUR_W-1:0]          task_duration_us,
	input  logic signed [STEPS_W-1:0] task_steps,
	input  ctrl_cmd_t                 cmd,
	output dp_status_t                status,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [3:0]                coil_levels,
	output logic [TICKS_W-1:0]        step_ticks,
	output logic                      task_done,
	output logic                      holding
);

	logic [TICKS_W-1:0] min_ticks_q, max_ticks_q;
	logic [2:0]         phase_q;
	logic [STEPS_W-1:0] steps_left_q;
	logic [1:0]         dir_q;
	logic [TICKS_W-1:0] tps_q;

	logic [STEPS_W-1:0] den_q;
	logic [STEPS_W-1:0] rem_q;
	logic [DUR_W-1:0]   num_q;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  prod_d;
	logic [PROD_W-1:0]  ticks_raw;

	logic [STEPS_W:0]   trial;
	logic               trial_ge;
	logic [STEPS_W-1:0] steps_mag;
	logic [STEPS_W-1:0] steps_raw;
	logic [STEPS_W-1:0] steps_dec;

	logic               out_valid_q;

	assign steps_raw = STEPS_W'(task_steps);
	assign steps_mag = ~steps_raw + 1'b1;
	assign steps_dec = steps_left_q - 1'b1;

	assign trial    = {rem_q, num_q[DUR_W-1]};
	assign trial_ge = (trial >= {1'b0, den_q});

	assign prod_d    = PROD_W'(num_q) * PROD_W'(TICK_SCALE);
	assign ticks_raw = prod_q >> TICK_SHIFT;

	assign status.dur_zero    = (task_duration_us == '0);
	assign status.out_blocked = out_valid_q & out_stall;
	assign out_valid          = out_valid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ticks_q <= MIN_TICKS_RST;
			max_ticks_q <= MAX_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_TICKS: min_ticks_q <= cfg_data;
				CFG_MAX_TICKS: max_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			steps_left_q <= '0;
			dir_q        <= DIR_NONE;
			tps_q        <= '0;
		end else begin
			if (cmd.stop_go) begin
				steps_left_q <= '0;
			end
			if (cmd.load_go) begin
				if (steps_raw == '0) begin
					steps_left_q <= DWELL_STEPS;
					dir_q        <= DIR_NONE;
				end else if (steps_raw[STEPS_W-1]) begin
					steps_left_q <= steps_mag;
					dir_q        <= DIR_REV;
				end else begin
					steps_left_q <= steps_raw;
					dir_q        <= DIR_FWD;
				end
			end
			if (cmd.step_go && steps_left_q != '0) begin
				if (dir_q == DIR_FWD) begin
					phase_q <= phase_q + 1'b1;
				end else if (dir_q == DIR_REV) begin
					phase_q <= phase_q - 1'b1;
				end
				steps_left_q <= steps_dec;
			end
			if (cmd.clamp_en) begin
				// max is tested first; with crossed bounds, above max gives max, else min
				if (ticks_raw > PROD_W'(max_ticks_q)) begin
					tps_q <= max_ticks_q;
				end else if (ticks_raw < PROD_W'(min_ticks_q)) begin
					tps_q <= min_ticks_q;
				end else begin
					tps_q <= ticks_raw[TICKS_W-1:0];
				end
			end
		end
	end

	// divider and scaling, quotient builds up in num_q
	always_ff @(posedge clk) begin
		if (cmd.load_go) begin
			num_q <= task_duration_us;
			rem_q <= '0;
			if (steps_raw == '0) begin
				den_q <= DWELL_STEPS;
			end else if (steps_raw[STEPS_W-1]) begin
				den_q <= steps_mag;
			end else begin
				den_q <= steps_raw;
			end
		end else if (cmd.div_step) begin
			num_q <= {num_q[DUR_W-2:0], trial_ge};
			if (trial_ge) begin
				rem_q <= STEPS_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[STEPS_W-1:0];
			end
		end
		if (cmd.scale_en) begin
			prod_q <= prod_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step_go) begin
			coil_levels <= ~half_step_mask(phase_q);
			step_ticks  <= tps_q;
			task_done   <= (steps_left_q == STEPS_W'(1));
			holding     <= (steps_left_q == '0);
		end
	end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the half-step task sequencer
// ----------------------------------------------------------------------------
// a directed table covers reset hold, clamp extremes, stop, dwell, reverse
// moves and the most negative step count. it is followed by random load and
// step sequences under several clamp settings, min above max among them. each
// step result is checked against a typed slot or a local move planner and coil
// model. both channels idle and stall at random. the receiver holds off once
// for a long spell; the sender pauses once per phase until all results are in.
// ----------------------------------------------------------------------------
module tb_top
	import shsts_pkg::*;
();

	localparam int NUM_ROWS      = 24;
	localparam int NUM_PHASES    = 7;
	localparam int PHASE_ITEMS   = 265;
	localparam int SETTLE_CYCLES = 40;
	localparam int REPORT_LIMIT  = 10;
	localparam int LONG_HOLD     = 400;
	localparam int RUN_LIMIT_NS  = 5_000_000;
	localparam int TICK_NUM      = 255;
	localparam int TICK_DEN      = 80;

	// half-step coil patterns, entry 0 in the low nibble
	localparam logic [7:0][3:0] COIL_PATTERN = {
		4'b1001, 4'b1000, 4'b1010, 4'b0010,
		4'b0110, 4'b0100, 4'b0101, 4'b0001
	};

	// one step slot as seen on the output channel
	typedef struct packed {
		logic [3:0]         coils;
		logic [TICKS_W-1:0] ticks;
		logic               done;
		logic               hold;
	} slot_t;

	// one row of the directed table
	typedef struct packed {
		logic               act;
		logic [DUR_W-1:0]   dur;
		logic [STEPS_W-1:0] cnt;
		logic               typed;   // want holds a hand-written slot
		slot_t              want;
	} row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic                      cfg_index;
	logic [TICKS_W-1:0]        cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic                      action;
	logic [DUR_W-1:0]          task_duration_us;
	logic signed [STEPS_W-1:0] task_steps;
	logic                      out_valid;
	logic                      out_stall;
	logic [3:0]                coil_levels;
	logic [TICKS_W-1:0]        step_ticks;
	logic                      task_done;
	logic                      holding;

	stepper_half_step_task_sequencer_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.task_duration_us (task_duration_us),
		.task_steps       (task_steps),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.coil_levels      (coil_levels),
		.step_ticks       (step_ticks),
		.task_done        (task_done),
		.holding          (holding)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// motor state as the block should hold it
	logic [2:0]         mv_phase;
	int unsigned        mv_left;
	logic [1:0]         mv_dir;
	logic [TICKS_W-1:0] mv_ticks;
	logic [TICKS_W-1:0] clamp_min;
	logic [TICKS_W-1:0] clamp_max;

	// step slots still owed by the block, oldest first
	slot_t coil_q[$];

	int mismatches;
	int n_loads, n_steps, n_done, n_hold, n_settings;
	bit tx_quiet, rx_quiet;
	int rx_hold_len;

	// new move: step count, direction and clamped step length
	function automatic void plan_move(input logic [DUR_W-1:0] dur,
			input logic [STEPS_W-1:0] cnt);
		longint unsigned len;
		if (dur == '0) begin
			mv_left = 0;    // stop keeps direction and step length
			return;
		end
		if (cnt == '0) begin
			mv_left = DWELL_STEPS;
			mv_dir  = DIR_NONE;
		end else if (cnt[STEPS_W-1]) begin
			mv_left = 32'h10000 - cnt;   // magnitude, 0x8000 gives 32768
			mv_dir  = DIR_REV;
		end else begin
			mv_left = cnt;
			mv_dir  = DIR_FWD;
		end
		len = dur / mv_left;
		len = len * TICK_NUM / TICK_DEN;
		// max is tested first; with crossed bounds, above max gives max, else min
		if (len > clamp_max)
			len = clamp_max;
		else if (len < clamp_min)
			len = clamp_min;
		mv_ticks = len[TICKS_W-1:0];
	endfunction

	// one step slot: current coils, then a half step unless held or dwelling
	function automatic slot_t advance_coils();
		slot_t s;
		s.coils = ~COIL_PATTERN[mv_phase];
		s.ticks = mv_ticks;
		s.done  = 1'b0;
		s.hold  = 1'b0;
		if (mv_left == 0) begin
			s.hold = 1'b1;
		end else begin
			if (mv_dir == DIR_FWD)
				mv_phase = mv_phase + 3'd1;
			else if (mv_dir == DIR_REV)
				mv_phase = mv_phase - 3'd1;
			mv_left = mv_left - 1;
			s.done  = (mv_left == 0);
		end
		return s;
	endfunction

	function automatic row_t ld(input logic [DUR_W-1:0] dur, input logic [STEPS_W-1:0] cnt);
		row_t r;
		r       = '0;
		r.act   = ACT_LOAD;
		r.dur   = dur;
		r.cnt   = cnt;
		return r;
	endfunction

	function automatic row_t st();
		row_t r;
		r     = '0;
		r.act = ACT_STEP;
		return r;
	endfunction

	function automatic row_t st_fix(input logic [3:0] coils, input logic [TICKS_W-1:0] ticks,
			input logic done, input logic hold);
		row_t r;
		r       = st();
		r.typed = 1'b1;
		r.want  = '{coils, ticks, done, hold};
		return r;
	endfunction

	// offer one transaction with a random lead-in gap, predict on acceptance
	task automatic offer(input logic act, input logic [DUR_W-1:0] dur,
			input logic [STEPS_W-1:0] cnt, input logic typed = 1'b0,
			input slot_t want = '0);
		int    gap;
		slot_t s;
		gap = tx_quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid         <= 1'b1;
		action           <= act;
		task_duration_us <= dur;
		task_steps       <= cnt;
		// stall only moves at rising edges, so the falling edge sees it settled
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		if (act == ACT_STEP) begin
			s = advance_coils();
			coil_q.push_back(typed ? want : s);
			n_steps++;
		end else begin
			plan_move(dur, cnt);
			n_loads++;
		end
	endtask

	// sender stops until every owed slot has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (coil_q.size() > 0) @(posedge clk);
	endtask

	// drain, then let a trailing step-length computation finish
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_clamp(input logic idx, input logic [TICKS_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_MIN_TICKS)
			clamp_min = val;
		else
			clamp_max = val;
	endtask

	// random move: mostly short counts, with dwell, stop and extreme counts
	task automatic pick_load(output logic [DUR_W-1:0] dur, output logic [STEPS_W-1:0] cnt,
			output int unsigned mag);
		int k;
		k = $urandom_range(0, 99);
		if (k < 10) begin
			cnt = '0;
		end else if (k < 65) begin
			mag = $urandom_range(1, 12);
			cnt = STEPS_W'($urandom_range(0, 1) ? -mag : mag);
		end else if (k < 72) begin
			case ($urandom_range(0, 2))
				0:       cnt = 16'h8000;
				1:       cnt = 16'h7FFF;
				default: cnt = 16'h8001;
			endcase
		end else begin
			cnt = STEPS_W'($urandom);
		end
		if (cnt == '0)
			mag = DWELL_STEPS;
		else if (cnt[STEPS_W-1])
			mag = 32'h10000 - cnt;
		else
			mag = cnt;
		k = $urandom_range(0, 99);
		if (k < 8)
			dur = '0;
		else if (k < 35)
			dur = DUR_W'($urandom);
		else if (k < 60)
			dur = DUR_W'($urandom_range(1, 2000));
		else   // near the clamps
			dur = DUR_W'(mag * $urandom_range(0, 12000) + $urandom_range(1, 40));
	endtask

	// one clamp setting: well-formed load-then-step runs plus some noise
	task automatic run_phase(input int p);
		int               sent;
		int               n;
		int unsigned      mag;
		bit               paused;
		logic [DUR_W-1:0] dur;
		logic [STEPS_W-1:0] cnt;
		sent   = 0;
		paused = 1'b0;
		// long receiver hold-off while the sender keeps offering
		if (p == 1)
			rx_hold_len = LONG_HOLD;
		while (sent < PHASE_ITEMS) begin
			if (sent % 50 < 4) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			if (!paused && sent >= 130) begin
				drain();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				// stray step or a load with no steps after it
				if ($urandom_range(0, 1)) begin
					offer(ACT_STEP, DUR_W'($urandom), STEPS_W'($urandom));
				end else begin
					pick_load(dur, cnt, mag);
					offer(ACT_LOAD, dur, cnt);
				end
				sent++;
			end else begin
				pick_load(dur, cnt, mag);
				offer(ACT_LOAD, dur, cnt);
				sent++;
				if (mag <= 12)
					n = $urandom_range(0, mag + 3);
				else if (mag <= DWELL_STEPS && $urandom_range(0, 7) == 0)
					n = mag + $urandom_range(0, 2);   // run a dwell or a shorter move to its end
				else
					n = $urandom_range(0, 10);
				repeat (n) begin
					// duration and count are ignored on a step, so let them toggle
					offer(ACT_STEP, DUR_W'($urandom), STEPS_W'($urandom));
					sent++;
				end
			end
		end
	endtask

	// result checker: outputs are stable between rising edges
	always @(negedge clk) begin
		slot_t got;
		slot_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{coil_levels, step_ticks, task_done, holding};
			n_done += got.done;
			n_hold += got.hold;
			if (coil_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%t: unexpected slot coils=%h ticks=%0d done=%b hold=%b",
						$realtime, got.coils, got.ticks, got.done, got.hold);
			end else begin
				want = coil_q.pop_front();
				if (got.coils !== want.coils || got.ticks !== want.ticks ||
						got.done !== want.done || got.hold !== want.hold) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%t: slot mismatch coils %h/%h ticks %0d/%0d done %b/%b hold %b/%b (exp/act)",
							$realtime, want.coils, got.coils, want.ticks, got.ticks,
							want.done, got.done, want.hold, got.hold);
				end
			end
		end
	end

	// receiver: random stall before each transaction, one long hold-off on request
	initial begin : rx_side
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_len > 0) begin
				n           = rx_hold_len;
				rx_hold_len = 0;
			end else begin
				n = rx_quiet ? 0 : $urandom_range(0, 3);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	// main sequence
	initial begin : stim
		row_t             dir_rows [NUM_ROWS];
		logic [TICKS_W-1:0] lo, hi;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_MIN_TICKS;
		cfg_data         = '0;
		in_valid         = 1'b0;
		action           = ACT_LOAD;
		task_duration_us = '0;
		task_steps       = '0;
		tx_quiet         = 1'b0;
		rx_quiet         = 1'b0;
		rx_hold_len      = 0;
		mismatches       = 0;
		n_loads          = 0;
		n_steps          = 0;
		n_done           = 0;
		n_hold           = 0;
		n_settings       = 0;
		mv_phase         = '0;
		mv_left          = 0;
		mv_dir           = DIR_NONE;
		mv_ticks         = '0;
		clamp_min        = MIN_TICKS_RST;
		clamp_max        = MAX_TICKS_RST;

		dir_rows = '{
			st_fix(4'hE, 15'd0, 1'b0, 1'b1),        // reset state holds phase 0
			ld(24'hFFFFFF, 16'd1),                  // longest move clamps to max
			st_fix(4'hE, 15'd32767, 1'b1, 1'b0),    // single step finishes the task
			st_fix(4'hA, 15'd32767, 1'b0, 1'b1),    // then holds phase 1
			ld(24'd1, 16'd1),
			ld(24'd1, 16'd32767),                   // rounds to zero, lower clamp
			st(),
			ld(24'd0, 16'd5),                       // zero duration stops the move
			st_fix(4'hB, 15'd1, 1'b0, 1'b1),        // stop keeps the step length
			ld(24'd1000, 16'd0),                    // dwell without motion
			st(),
			st(),
			ld(24'd5000, -16'sd3),                  // reverse through phase 0
			st(),
			st(),
			st(),
			ld(24'hFFFFFF, 16'h8000),               // most negative count
			st(),
			st(),
			ld(24'hFFFFFF, 16'd32767),
			st(),
			ld(24'd10, -16'sd1),
			st(),
			st()
		};
		// ignored fields at their top on the last step
		dir_rows[NUM_ROWS-1].dur = '1;
		dir_rows[NUM_ROWS-1].cnt = '1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table with reset clamps
		for (int i = 0; i < NUM_ROWS; i++)
			offer(dir_rows[i].act, dir_rows[i].dur, dir_rows[i].cnt,
				dir_rows[i].typed, dir_rows[i].want);
		settle();

		// random runs, one clamp setting each
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin lo = 15'd1;     hi = 15'd32767; end
				1: begin lo = 15'd32767; hi = 15'd32767; end
				2: begin lo = 15'd32767; hi = 15'd1;     end   // crossed bounds
				3: begin lo = 15'd1;     hi = 15'd1;     end
				4: begin lo = 15'd50;    hi = 15'd3000;  end
				5: begin lo = 15'd3000;  hi = 15'd50;    end
				default: begin
					lo = TICKS_W'($urandom_range(1, 32767));
					hi = TICKS_W'($urandom_range(1, 32767));
				end
			endcase
			write_clamp(CFG_MIN_TICKS, lo);
			write_clamp(CFG_MAX_TICKS, hi);
			n_settings++;
			run_phase(p);
			settle();
		end

		$display("ran %0d loads and %0d step slots under %0d clamp settings",
			n_loads, n_steps, n_settings);
		$display("saw %0d finished tasks and %0d held slots, %0d mismatches",
			n_done, n_hold, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#RUN_LIMIT_NS;
		$display("timeout with %0d slots still owed", coil_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
